// ===== hdl/bcr_pkg.sv =====
// Shared types, register map, mode codes and BCD helper functions
// for the BCD real-time clock. No dependencies.
package bcr_pkg;

    localparam int DataW = 8;
    localparam int AddrW = 8;
    localparam int ModeW = 2;
    localparam int DowW  = 4;

    localparam logic [ModeW-1:0] MODE_TICK  = 2'd0;
    localparam logic [ModeW-1:0] MODE_READ  = 2'd1;
    localparam logic [ModeW-1:0] MODE_WRITE = 2'd2;

    localparam logic [AddrW-1:0] ADDR_ENABLE  = 8'h90;
    localparam logic [AddrW-1:0] ADDR_YEAR    = 8'h91;
    localparam logic [AddrW-1:0] ADDR_MONTH   = 8'h92;
    localparam logic [AddrW-1:0] ADDR_DAY     = 8'h93;
    localparam logic [AddrW-1:0] ADDR_HOUR    = 8'h94;
    localparam logic [AddrW-1:0] ADDR_MINUTE  = 8'h95;
    localparam logic [AddrW-1:0] ADDR_SECOND  = 8'h96;
    localparam logic [AddrW-1:0] ADDR_WEEKDAY = 8'h97;

    localparam logic [DataW-1:0] LIM_SECOND = 8'h59;
    localparam logic [DataW-1:0] LIM_HOUR   = 8'h23;
    localparam logic [DataW-1:0] LIM_MONTH  = 8'h12;
    localparam logic [DataW-1:0] LIM_YEAR   = 8'h99;
    localparam logic [DataW-1:0] DAYS_FEB_LEAP = 8'h29;
    localparam logic [DataW-1:0] DAYS_FEB      = 8'h28;
    localparam logic [DataW-1:0] DAYS_SHORT    = 8'h30;
    localparam logic [DataW-1:0] DAYS_LONG     = 8'h31;
    localparam logic [DataW-1:0] MONTH_FEB = 8'h02;
    localparam logic [DataW-1:0] MONTH_APR = 8'h04;
    localparam logic [DataW-1:0] MONTH_JUN = 8'h06;
    localparam logic [DataW-1:0] MONTH_SEP = 8'h09;
    localparam logic [DataW-1:0] MONTH_NOV = 8'h11;
    localparam logic [DowW-1:0]  DOW_WRAP  = 4'd7;

    localparam logic [DataW-1:0] RST_YEAR   = 8'h00;
    localparam logic [DataW-1:0] RST_MONTH  = 8'h01;
    localparam logic [DataW-1:0] RST_DAY    = 8'h01;
    localparam logic [DataW-1:0] RST_HOUR   = 8'h00;
    localparam logic [DataW-1:0] RST_MINUTE = 8'h00;
    localparam logic [DataW-1:0] RST_SECOND = 8'h00;
    localparam logic [DowW-1:0]  RST_DOW    = 4'd0;

    typedef struct packed {
        logic             run_en;
        logic [DataW-1:0] year;
        logic [DataW-1:0] month;
        logic [DataW-1:0] day;
        logic [DataW-1:0] hour;
        logic [DataW-1:0] minute;
        logic [DataW-1:0] second;
        logic [DowW-1:0]  dow;
    } t_time;

    function automatic logic [DataW-1:0] bcd_inc(input logic [DataW-1:0] v);
        logic [DataW-1:0] r;
        r = v + 8'd1;
        if (r[3:0] > 4'd9) begin
            r = r + 8'd6;
        end
        return r;
    endfunction

    // decimal year mod 4 = (2*tens + ones) mod 4
    function automatic logic [1:0] leap_phase(input logic [DataW-1:0] year);
        return {year[4], 1'b0} + year[1:0];
    endfunction

    function automatic logic [DataW-1:0] month_len(input logic [DataW-1:0] month,
                                                   input logic [DataW-1:0] year);
        logic [DataW-1:0] len;
        unique case (month)
            MONTH_FEB: begin
                len = (leap_phase(year) == 2'd0) ? DAYS_FEB_LEAP : DAYS_FEB;
            end
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: begin
                len = DAYS_SHORT;
            end
            default: begin
                len = DAYS_LONG;
            end
        endcase
        return len;
    endfunction

endpackage

// ===== hdl/bcr_tick.sv =====
// One-second advance of the BCD time and calendar while run_en is set, combinational.
// Depends on bcr_pkg.
module bcr_tick (
    input  bcr_pkg::t_time i_time,
    output bcr_pkg::t_time o_time
);

    always_comb begin
        logic [bcr_pkg::DataW-1:0] sec;
        logic [bcr_pkg::DataW-1:0] min;
        logic [bcr_pkg::DataW-1:0] hr;
        logic [bcr_pkg::DataW-1:0] dy;
        logic [bcr_pkg::DataW-1:0] mon;
        logic [bcr_pkg::DataW-1:0] yr;
        logic [bcr_pkg::DowW-1:0]  dw;
        sec = bcr_pkg::bcd_inc(i_time.second);
        min = bcr_pkg::bcd_inc(i_time.minute);
        hr  = bcr_pkg::bcd_inc(i_time.hour);
        dy  = bcr_pkg::bcd_inc(i_time.day);
        mon = bcr_pkg::bcd_inc(i_time.month);
        yr  = bcr_pkg::bcd_inc(i_time.year);
        dw  = i_time.dow + 4'd1;
        o_time = i_time;
        if (i_time.run_en) begin
            if (sec <= bcr_pkg::LIM_SECOND) begin
                o_time.second = sec;
            end else begin
                o_time.second = '0;
                if (min <= bcr_pkg::LIM_SECOND) begin
                    o_time.minute = min;
                end else begin
                    o_time.minute = '0;
                    if (hr <= bcr_pkg::LIM_HOUR) begin
                        o_time.hour = hr;
                    end else begin
                        o_time.hour = '0;
                        o_time.dow  = (dw >= bcr_pkg::DOW_WRAP) ? '0 : dw;
                        if (dy <= bcr_pkg::month_len(i_time.month, i_time.year)) begin
                            o_time.day = dy;
                        end else begin
                            o_time.day = 8'h01;
                            if (mon <= bcr_pkg::LIM_MONTH) begin
                                o_time.month = mon;
                            end else begin
                                o_time.month = 8'h01;
                                o_time.year  = (yr > bcr_pkg::LIM_YEAR) ? '0 : yr;
                            end
                        end
                    end
                end
            end
        end
    end

endmodule

// ===== hdl/bcr_regfile.sv =====
// Clock and calendar registers with register-map read and write.
// Depends on bcr_pkg and bcr_tick.
module bcr_regfile (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [bcr_pkg::ModeW-1:0]   i_mode,
    input  logic [bcr_pkg::AddrW-1:0]   i_address,
    input  logic [bcr_pkg::DataW-1:0]   i_write_data,
    output logic [bcr_pkg::DataW-1:0]   o_read_data
);

    bcr_pkg::t_time r_time;
    bcr_pkg::t_time n_time;
    bcr_pkg::t_time w_ticked;

    bcr_tick u_tick (
        .i_time (r_time),
        .o_time (w_ticked)
    );

    always_comb begin
        n_time = r_time;
        if (i_en) begin
            if (i_mode == bcr_pkg::MODE_TICK) begin
                n_time = w_ticked;
            end else if (i_mode == bcr_pkg::MODE_WRITE) begin
                unique case (i_address)
                    bcr_pkg::ADDR_ENABLE:  n_time.run_en = i_write_data[0];
                    bcr_pkg::ADDR_YEAR:    n_time.year   = i_write_data;
                    bcr_pkg::ADDR_MONTH:   n_time.month  = i_write_data;
                    bcr_pkg::ADDR_DAY:     n_time.day    = i_write_data;
                    bcr_pkg::ADDR_HOUR:    n_time.hour   = i_write_data;
                    bcr_pkg::ADDR_MINUTE:  n_time.minute = i_write_data;
                    bcr_pkg::ADDR_SECOND:  n_time.second = i_write_data;
                    bcr_pkg::ADDR_WEEKDAY: n_time.dow    = i_write_data[3:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_read_data = '0;
        if (i_mode == bcr_pkg::MODE_READ) begin
            unique case (i_address)
                bcr_pkg::ADDR_ENABLE:  o_read_data = {7'd0, r_time.run_en};
                bcr_pkg::ADDR_YEAR:    o_read_data = r_time.year;
                bcr_pkg::ADDR_MONTH:   o_read_data = r_time.month;
                bcr_pkg::ADDR_DAY:     o_read_data = r_time.day;
                bcr_pkg::ADDR_HOUR:    o_read_data = r_time.hour;
                bcr_pkg::ADDR_MINUTE:  o_read_data = r_time.minute;
                bcr_pkg::ADDR_SECOND:  o_read_data = r_time.second;
                bcr_pkg::ADDR_WEEKDAY: begin
                    o_read_data = {2'd0, bcr_pkg::leap_phase(r_time.year), r_time.dow};
                end
                default: o_read_data = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time.run_en <= 1'b1;
            r_time.year   <= bcr_pkg::RST_YEAR;
            r_time.month  <= bcr_pkg::RST_MONTH;
            r_time.day    <= bcr_pkg::RST_DAY;
            r_time.hour   <= bcr_pkg::RST_HOUR;
            r_time.minute <= bcr_pkg::RST_MINUTE;
            r_time.second <= bcr_pkg::RST_SECOND;
            r_time.dow    <= bcr_pkg::RST_DOW;
        end else begin
            r_time <= n_time;
        end
    end

endmodule

// ===== hdl/bcd_calendar_rtc_unit.sv =====
// An accepted word waits in the input register, its result in the result
// register. Throughput: one word per cycle while results are taken; the two
// registers part the two sides, so a stalled result does not block intake
// until both hold a word. Reset (synchronous, active low) empties both
// stages and sets the clock to enabled, 00-01-01 00:00:00, weekday 0.
module bcd_calendar_rtc_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] address, [15:8] write_data
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [7:0] read_data
);

    logic                        r_in_valid;
    logic [bcr_pkg::ModeW-1:0]   r_mode;
    logic [bcr_pkg::AddrW-1:0]   r_address;
    logic [bcr_pkg::DataW-1:0]   r_write_data;
    logic                        r_out_valid;
    logic [bcr_pkg::DataW-1:0]   r_out_data;
    logic                        w_advance;
    logic [bcr_pkg::DataW-1:0]   w_read_data;

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    bcr_regfile u_regfile (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_advance),
        .i_mode       (r_mode),
        .i_address    (r_address),
        .i_write_data (r_write_data),
        .o_read_data  (w_read_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_mode       <= s_axis_tuser;
            r_address    <= s_axis_tdata[7:0];
            r_write_data <= s_axis_tdata[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= w_read_data;
        end
    end

`ifndef SYNTHESIS
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid && !m_axis_tready))
        else $error("intake stalled without a full pipeline");

    a_advance_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> m_axis_tvalid)
        else $error("processed word produced no result");

    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_mode != bcr_pkg::MODE_READ) |=> (m_axis_tdata == 8'd0))
        else $error("non-read word returned nonzero data");

    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_in_valid)
        else $error("accepted word lost from input register");
`endif

endmodule
